// ----- rtl/fwrf_pkg.sv -----
// shared types and constants of the fixed-width radix formatter
package fwrf_pkg;

  localparam int unsigned MaxDigitsDef = 32;
  localparam int unsigned OpWidth      = 2;
  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned CountWidth   = 6;
  localparam int unsigned CharWidth    = 7;
  localparam int unsigned DigitWidth   = 4;

  typedef enum logic [OpWidth-1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_BIN  = 2'd3
  } op_e;

  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharA     = 7'h41;
  localparam logic [CharWidth-1:0] CharPlus  = 7'h2B;
  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

  // reciprocal of ten scaled by 2^35
  localparam logic [ValueWidth-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned           RecipShift = 35;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit_sign;
    logic emit_digit;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d < 4'd10) begin
      c = CharZero + CharWidth'(d);
    end else begin
      c = CharA + CharWidth'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ----- rtl/fwrf_in_if.sv -----
// request and result channel interfaces
interface fwrf_in_if;
  logic                            valid;
  logic                            ready;
  logic [fwrf_pkg::OpWidth-1:0]    op;
  logic [fwrf_pkg::ValueWidth-1:0] value;
  logic [fwrf_pkg::CountWidth-1:0] digit_count;

  modport source (output valid, op, value, digit_count, input ready);
  modport sink   (input valid, op, value, digit_count, output ready);
endinterface

interface fwrf_out_if;
  logic                           valid;
  logic                           ready;
  logic [fwrf_pkg::CharWidth-1:0] character;
  logic                           last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

// ----- rtl/fwrf_ctrl.sv -----
// sequencer of the formatter: digit extraction then character emission
module fwrf_ctrl #(
  parameter int unsigned MAX_DIGITS = fwrf_pkg::MaxDigitsDef,
  localparam int unsigned IdxWidth  = $clog2(MAX_DIGITS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fwrf_in_if.sink              req_i,
  input  fwrf_pkg::status_t    status_i,
  output fwrf_pkg::cmd_t       cmd_o,
  output logic [IdxWidth-1:0]  idx_o
);
  import fwrf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [IdxWidth-1:0]  idx_q, idx_d;
  logic [IdxWidth-1:0]  last_idx_q, last_idx_d;
  logic                 sdec_q, sdec_d;
  logic [IdxWidth-1:0]  clamp_idx;

  // digit count to index of the top digit, zero treated as one, counts above MAX_DIGITS saturated
  always_comb begin
    if (req_i.digit_count == '0) begin
      clamp_idx = '0;
    end else if (int'(req_i.digit_count) > int'(MAX_DIGITS)) begin
      clamp_idx = IdxWidth'(MAX_DIGITS - 1);
    end else begin
      clamp_idx = IdxWidth'(req_i.digit_count - 6'd1);
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign idx_o       = idx_q;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    sdec_d     = sdec_q;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          last_idx_d = clamp_idx;
          sdec_d     = (op_e'(req_i.op) == OP_SDEC);
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
        if (idx_q == last_idx_q) begin
          state_d = sdec_q ? ST_SIGN : ST_EMIT;
        end else begin
          idx_d = idx_q + IdxWidth'(1);
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          cmd_o.last       = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - IdxWidth'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      last_idx_q <= '0;
      sdec_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
      sdec_q     <= sdec_d;
    end
  end

endmodule

// ----- rtl/fwrf_dp.sv -----
// datapath: working value, digit buffer and output register
module fwrf_dp #(
  parameter int unsigned MAX_DIGITS = fwrf_pkg::MaxDigitsDef,
  localparam int unsigned IdxWidth  = $clog2(MAX_DIGITS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fwrf_in_if.sink              req_i,
  fwrf_out_if.source           rsp_o,
  input  fwrf_pkg::cmd_t       cmd_i,
  input  logic [IdxWidth-1:0]  idx_i,
  output fwrf_pkg::status_t    status_o
);
  import fwrf_pkg::*;

  logic [ValueWidth-1:0] value_q;
  op_e                   op_q;
  logic                  neg_q;
  logic [DigitWidth-1:0] digits_q [MAX_DIGITS];

  logic [2*ValueWidth-1:0] prod;
  logic [ValueWidth-1:0]   quot_dec;
  logic [ValueWidth-1:0]   rem_dec;
  logic [ValueWidth-1:0]   quot;
  logic [DigitWidth-1:0]   digit;
  logic                    in_neg;

  logic                    out_valid_q;
  logic [CharWidth-1:0]    out_char_q;
  logic                    out_last_q;

  // divide by ten through the scaled reciprocal
  assign prod     = (2*ValueWidth)'(value_q) * (2*ValueWidth)'(RecipTen);
  assign quot_dec = ValueWidth'(prod >> RecipShift);
  assign rem_dec  = value_q - ((quot_dec << 3) + (quot_dec << 1));

  always_comb begin
    case (op_q)
      OP_HEX: begin
        digit = value_q[3:0];
        quot  = value_q >> 4;
      end
      OP_BIN: begin
        digit = {3'b000, value_q[0]};
        quot  = value_q >> 1;
      end
      default: begin
        digit = rem_dec[DigitWidth-1:0];
        quot  = quot_dec;
      end
    endcase
  end

  assign in_neg = (op_e'(req_i.op) == OP_SDEC) && req_i.value[ValueWidth-1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(req_i.op);
      neg_q   <= in_neg;
      value_q <= in_neg ? (ValueWidth'(0) - req_i.value) : req_i.value;
    end else if (cmd_i.step) begin
      value_q <= quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      digits_q[idx_i] <= digit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_char_q <= neg_q ? CharMinus : CharPlus;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_char_q <= digit_char(digits_q[idx_i]);
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_sign || cmd_i.emit_digit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.character   = out_char_q;
  assign rsp_o.last        = out_last_q;

endmodule

// ----- rtl/fixed_width_radix_formatter_core.sv -----
// top level of the fixed-width radix formatter
// extraction: n = clamped digit count; digits are extracted one per cycle, lsd first,
//   then the characters are emitted msd first, led by a sign character for signed decimal
// a new request is taken only once the previous one has emitted its last character
// emission waits for the whole extraction since the msd comes out last
// reset is asynchronous, active low; it clears the sequencer and output valid only
module fixed_width_radix_formatter_core #(
  parameter int unsigned MAX_DIGITS = fwrf_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwrf_in_if.sink     req_i,
  fwrf_out_if.source  rsp_o
);
  import fwrf_pkg::*;

  localparam int unsigned IdxWidth = $clog2(MAX_DIGITS);

  // command and status between sequencer and datapath
  cmd_t                cmd;
  status_t             status;
  logic [IdxWidth-1:0] idx;

  // sequencer: accepts a request, walks digits up then back down
  fwrf_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .status_i (status),
    .cmd_o    (cmd),
    .idx_o    (idx)
  );

  // datapath: captures the value, extracts digits lsd first, emits msd first
  fwrf_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .rsp_o    (rsp_o),
    .cmd_i    (cmd),
    .idx_i    (idx),
    .status_o (status)
  );

endmodule

// ----- tb/fwrf_text_check.sv -----
// checker that predicts the formatter's characters and compares them on the result channel
module fwrf_text_check #(
  parameter int unsigned MAX_DIGITS = fwrf_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwrf_in_if          req_i,
  fwrf_out_if         rsp_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned chars_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fwrf_pkg::*;

  typedef struct packed {
    logic [CharWidth-1:0] character;
    logic                 last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t owed_text[$];

  function automatic logic [CharWidth-1:0] glyph_of(input logic [DigitWidth-1:0] d);
    logic [CharWidth-1:0] g;
    if (d > 4'd9) begin
      g = CharA + CharWidth'(d) - CharWidth'(10);
    end else begin
      g = CharZero + CharWidth'(d);
    end
    return g;
  endfunction

  // appends the text of one request to the owed characters
  function automatic void render_value(input op_e op, input logic [ValueWidth-1:0] value,
                                       input logic [CountWidth-1:0] count);
    logic [ValueWidth-1:0] mag;
    logic [DigitWidth-1:0] digs[MAX_DIGITS];
    int unsigned           width;
    int unsigned           base;
    mag = value;
    if (count == '0) begin
      width = 1;
    end else if (int'(count) > int'(MAX_DIGITS)) begin
      width = MAX_DIGITS;
    end else begin
      width = int'(count);
    end
    case (op)
      OP_HEX:  base = 16;
      OP_BIN:  base = 2;
      default: base = 10;
    endcase
    if (op == OP_SDEC) begin
      owed_text.push_back('{character: mag[ValueWidth-1] ? CharMinus : CharPlus, last: 1'b0});
      if (mag[ValueWidth-1]) begin
        mag = '0 - mag;
      end
    end
    // low digit first, a spent value keeps giving zeros
    for (int p = 0; p < int'(width); p++) begin
      digs[p] = DigitWidth'(mag % base);
      mag     = mag / base;
    end
    for (int p = int'(width) - 1; p >= 0; p--) begin
      owed_text.push_back('{character: glyph_of(digs[p]), last: (p == 0)});
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        render_value(op_e'(req_i.op), req_i.value, req_i.digit_count);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_text.size() == 0) begin
          $error("character: expected none, actual %h", rsp_i.character);
          mismatch_cnt_o++;
        end else begin
          want = owed_text.pop_front();
          if (rsp_i.character !== want.character) begin
            $error("character: expected %h, actual %h", want.character, rsp_i.character);
            mismatch_cnt_o++;
          end
          if (rsp_i.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, rsp_i.last);
            mismatch_cnt_o++;
          end
        end
      end
    end
    chars_owed_o = owed_text.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// top of the formatter testbench: clock, reset, request and ready stimulus, verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fwrf_pkg::*;

  localparam int unsigned RandReqs    = 400;
  localparam int unsigned CalmTail    = 60;   // last requests run with no idling at all
  localparam int unsigned HoldAt      = 40;   // random request at which the long hold starts
  localparam int unsigned LongHold    = 300;  // well beyond one worst case request
  localparam int unsigned DrainCycles = 80;   // about one worst case request after the last char

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  bit          calm;         // set for the tail of the run, stops idling on both sides
  bit          hold_asked;   // asks the receiver for its one long hold-off
  int unsigned mismatch_cnt;
  int unsigned chars_owed;

  fwrf_in_if  req_if();
  fwrf_out_if rsp_if();

  fixed_width_radix_formatter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // watches both channels, predicts every character and counts mismatches
  fwrf_text_check u_text_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .chars_owed_o   (chars_owed)
  );

  always #10 clk_i = ~clk_i;

  // offers one request, sometimes after an idle burst, and returns at the edge that takes it
  task automatic offer_req(input op_e op, input logic [ValueWidth-1:0] value,
                           input logic [CountWidth-1:0] count);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.op          <= op;
    req_if.value       <= value;
    req_if.digit_count <= count;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  initial begin : req_gen
    logic [ValueWidth-1:0] val;
    logic [CountWidth-1:0] cnt;
    req_if.valid       <= 1'b0;
    req_if.op          <= OP_UDEC;
    req_if.value       <= '0;
    req_if.digit_count <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every format and the corner cases
    offer_req(OP_UDEC, 32'h0000_0000, 6'd1);
    offer_req(OP_UDEC, 32'hFFFF_FFFF, 6'd10);
    offer_req(OP_UDEC, 32'hFFFF_FFFF, 6'd32);  // leading positions beyond the value read zero
    offer_req(OP_UDEC, 32'd12345, 6'd3);       // high digits silently dropped
    offer_req(OP_UDEC, 32'd7, 6'd0);           // zero count still gives one digit
    offer_req(OP_UDEC, 32'h0000_0000, 6'd63);  // count above the maximum saturates
    offer_req(OP_SDEC, 32'h8000_0000, 6'd10);  // most negative, magnitude 2147483648
    offer_req(OP_SDEC, 32'h8000_0000, 6'd32);
    offer_req(OP_SDEC, 32'h7FFF_FFFF, 6'd10);
    offer_req(OP_SDEC, 32'h0000_0000, 6'd1);   // zero takes the plus sign
    offer_req(OP_SDEC, 32'hFFFF_FFFF, 6'd3);
    offer_req(OP_SDEC, 32'hFFFF_FF85, 6'd40);
    offer_req(OP_HEX, 32'hFFFF_FFFF, 6'd8);
    offer_req(OP_HEX, 32'h0123_ABCD, 6'd4);
    offer_req(OP_HEX, 32'hDEAD_BEEF, 6'd32);
    offer_req(OP_HEX, 32'h89AB_CDEF, 6'd63);
    offer_req(OP_BIN, 32'hAAAA_AAAA, 6'd32);
    offer_req(OP_BIN, 32'h5555_5555, 6'd33);
    offer_req(OP_BIN, 32'hFFFF_FFFF, 6'd5);
    offer_req(OP_BIN, 32'h0000_0000, 6'd0);

    // random: values clustered around the edges of each range, mostly short widths
    for (int i = 0; i < RandReqs; i++) begin
      if (i == HoldAt) begin
        hold_asked = 1'b1;
      end
      if (i == RandReqs - CalmTail) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 5))
        0:       val = $urandom_range(0, 999);
        1:       val = 32'hFFFF_FFFF - $urandom_range(0, 999);
        2:       val = 32'h8000_0000 + $urandom_range(0, 999);
        3:       val = 32'h7FFF_FFFF - $urandom_range(0, 999);
        default: val = $urandom();
      endcase
      if ($urandom_range(0, 9) == 0) begin
        cnt = CountWidth'($urandom_range(0, 63));
      end else begin
        cnt = CountWidth'($urandom_range(1, 12));
      end
      offer_req(op_e'($urandom_range(0, 3)), val, cnt);
    end
    req_if.valid <= 1'b0;

    // drain: wait for every owed character, then a worst case request length more
    @(posedge clk_i);
    while (chars_owed != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: ready bursts, random stalls, one long hold-off that backs up the request side
  initial begin : rsp_ready_gen
    bit hold_served;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_asked && !hold_served) begin
        hold_served = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fwrf_pkg.sv
rtl/fwrf_in_if.sv
rtl/fwrf_ctrl.sv
rtl/fwrf_dp.sv
rtl/fixed_width_radix_formatter_core.sv
tb/fwrf_text_check.sv
tb/tb_top.sv
